>>> hdl/sorted_priority_queue_top_assert.svh
// assertion macros used by the checker file of the sorted priority queue
// depends on nothing; expects clk_i and rst_ni in the scope of use
`ifndef SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SPQ_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sorted priority queue check failed");

// next-cycle implication, checked outside reset
`define SPQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sorted priority queue check failed");

`endif

>>> hdl/spq_pkg.sv
// types, codes and sizes of the sorted priority queue
// used by every module of the block; depends on nothing
package spq_pkg;

  localparam int unsigned CAPACITY  = 16;
  localparam int unsigned CNT_W     = $clog2(CAPACITY + 1);
  localparam int unsigned CNT_OUT_W = 5;
  localparam int unsigned ID_W      = 16;
  localparam int unsigned CLS_W     = 2;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_LOOKUP = 2'd2,
    MODE_NOP    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_DONE      = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } state_e;

  typedef struct packed {
    logic [1:0]       mode;
    logic [ID_W-1:0]  key_id;
    logic [CLS_W-1:0] priority_class;
  } in_item_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [CLS_W-1:0]     found_class;
    logic                 head_valid;
    logic [ID_W-1:0]      head_id;
    logic [CLS_W-1:0]     head_class;
    logic [CNT_OUT_W-1:0] count_class0;
    logic [CNT_OUT_W-1:0] count_class1;
    logic [CNT_OUT_W-1:0] count_other;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic load_item;
    logic cmp;
    logic upd;
  } dp_cmd_t;

endpackage

>>> hdl/spq_ctrl.sv
// controller of the sorted priority queue: handshakes and step sequencing
// depends on spq_pkg
module spq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output spq_pkg::dp_cmd_t cmd_o
);

  spq_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      spq_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = spq_pkg::ST_CMP;
      end
      spq_pkg::ST_CMP: begin
        state_d = spq_pkg::ST_UPD;
      end
      spq_pkg::ST_UPD: begin
        if (out_free) state_d = in_valid_i ? spq_pkg::ST_CMP : spq_pkg::ST_IDLE;
      end
      default: begin
        state_d = spq_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == spq_pkg::ST_IDLE) ||
                 ((state_q == spq_pkg::ST_UPD) && out_free);
    cmd_o.load_item = in_valid_i && in_ready_o;
    cmd_o.cmp       = (state_q == spq_pkg::ST_CMP);
    cmd_o.upd       = (state_q == spq_pkg::ST_UPD) && out_free;
    if (cmd_o.upd) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spq_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> hdl/spq_datapath.sv
// datapath of the sorted priority queue: sorted slot row, compare flags,
// class counters and result register; depends on spq_pkg
module spq_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  spq_pkg::dp_cmd_t   cmd_i,
  input  spq_pkg::in_item_t  in_item_i,
  output spq_pkg::out_item_t out_item_o
);

  localparam int unsigned CAP = spq_pkg::CAPACITY;

  spq_pkg::in_item_t item_q;

  logic [spq_pkg::ID_W-1:0]  id_q  [CAP];
  logic [spq_pkg::ID_W-1:0]  id_d  [CAP];
  logic [spq_pkg::CLS_W-1:0] cls_q [CAP];
  logic [spq_pkg::CLS_W-1:0] cls_d [CAP];

  logic [spq_pkg::CNT_W-1:0] occ_q, occ_d;
  logic [spq_pkg::CNT_W-1:0] c0_q, c0_d, c1_q, c1_d, cg_q, cg_d;

  logic [CAP-1:0] after_q, after_d;  // new entry goes at or before this cell
  logic [CAP-1:0] match_q, match_d;
  logic [CAP-1:0] any_le, first;

  logic                      full, hit, do_ins, do_rem;
  logic [spq_pkg::CLS_W-1:0] found_cls;
  spq_pkg::out_item_t        res_q, res_d;

  // per-cell compare against the held item
  always_comb begin
    logic valid;
    for (int i = 0; i < CAP; i++) begin
      valid = (spq_pkg::CNT_W'(i) < occ_q);
      after_d[i] = !valid ||
                   (item_q.priority_class < cls_q[i]) ||
                   ((item_q.priority_class == cls_q[i]) && (item_q.key_id < id_q[i]));
      match_d[i] = valid && (id_q[i] == item_q.key_id);
    end
  end

  // first match in sorted order, each cell from a masked reduction of its own
  always_comb begin
    found_cls = '0;
    for (int i = 0; i < CAP; i++) begin
      any_le[i] = |(match_q & ({CAP{1'b1}} >> (CAP - 1 - i)));
    end
    for (int i = 0; i < CAP; i++) begin
      if (i == 0) begin
        first[i] = any_le[i];
      end else begin
        first[i] = any_le[i] && !any_le[(i == 0) ? 0 : i-1];
      end
      found_cls = found_cls | (first[i] ? cls_q[i] : '0);
    end
  end

  assign full   = (occ_q == spq_pkg::CNT_W'(CAP));
  assign hit    = any_le[CAP-1];
  assign do_ins = (item_q.mode == spq_pkg::MODE_INSERT) && !full;
  assign do_rem = (item_q.mode == spq_pkg::MODE_REMOVE) && hit;

  // shift row
  always_comb begin
    for (int i = 0; i < CAP; i++) begin
      id_d[i]  = id_q[i];
      cls_d[i] = cls_q[i];
      if (do_ins && after_q[i]) begin
        if (i == 0 || !after_q[(i == 0) ? 0 : i-1]) begin
          id_d[i]  = item_q.key_id;
          cls_d[i] = item_q.priority_class;
        end else begin
          id_d[i]  = id_q[(i == 0) ? 0 : i-1];
          cls_d[i] = cls_q[(i == 0) ? 0 : i-1];
        end
      end else if (do_rem && any_le[i] && (i < CAP - 1)) begin
        id_d[i]  = id_q[(i < CAP - 1) ? i+1 : i];
        cls_d[i] = cls_q[(i < CAP - 1) ? i+1 : i];
      end
    end
  end

  // occupancy and class counters
  always_comb begin
    logic [spq_pkg::CLS_W-1:0] dcls;
    occ_d = occ_q;
    c0_d  = c0_q;
    c1_d  = c1_q;
    cg_d  = cg_q;
    dcls  = do_ins ? item_q.priority_class : found_cls;
    if (do_ins) begin
      occ_d = occ_q + spq_pkg::CNT_W'(1);
      priority if (dcls == spq_pkg::CLS_W'(0)) c0_d = c0_q + spq_pkg::CNT_W'(1);
      else if (dcls == spq_pkg::CLS_W'(1))     c1_d = c1_q + spq_pkg::CNT_W'(1);
      else                                     cg_d = cg_q + spq_pkg::CNT_W'(1);
    end else if (do_rem) begin
      occ_d = occ_q - spq_pkg::CNT_W'(1);
      priority if (dcls == spq_pkg::CLS_W'(0)) c0_d = c0_q - spq_pkg::CNT_W'(1);
      else if (dcls == spq_pkg::CLS_W'(1))     c1_d = c1_q - spq_pkg::CNT_W'(1);
      else                                     cg_d = cg_q - spq_pkg::CNT_W'(1);
    end
  end

  // result beat from the state after this step
  always_comb begin
    res_d.status      = spq_pkg::STATUS_DONE;
    res_d.found_class = '0;
    unique case (item_q.mode)
      spq_pkg::MODE_INSERT: begin
        if (full) res_d.status = spq_pkg::STATUS_FULL;
      end
      spq_pkg::MODE_REMOVE, spq_pkg::MODE_LOOKUP: begin
        if (hit) begin
          res_d.found_class = found_cls;
        end else begin
          res_d.status = spq_pkg::STATUS_NOT_FOUND;
        end
      end
      default: begin
        res_d.status = spq_pkg::STATUS_DONE;
      end
    endcase
    res_d.head_valid   = (occ_d != '0);
    res_d.head_id      = res_d.head_valid ? id_d[0] : '0;
    res_d.head_class   = res_d.head_valid ? cls_d[0] : '0;
    res_d.count_class0 = spq_pkg::CNT_OUT_W'(c0_d);
    res_d.count_class1 = spq_pkg::CNT_OUT_W'(c1_d);
    res_d.count_other  = spq_pkg::CNT_OUT_W'(cg_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
      c0_q  <= '0;
      c1_q  <= '0;
      cg_q  <= '0;
    end else if (cmd_i.upd) begin
      occ_q <= occ_d;
      c0_q  <= c0_d;
      c1_q  <= c1_d;
      cg_q  <= cg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) item_q <= in_item_i;
    if (cmd_i.cmp) begin
      after_q <= after_d;
      match_q <= match_d;
    end
    if (cmd_i.upd) begin
      res_q <= res_d;
      for (int i = 0; i < CAP; i++) begin
        id_q[i]  <= id_d[i];
        cls_q[i] <= cls_d[i];
      end
    end
  end

  assign out_item_o = res_q;

endmodule

>>> hdl/sorted_priority_queue_top.sv
// Sorted priority queue of up to spq_pkg::CAPACITY entries (identifier and
// class), kept ordered by class then identifier in a compare-and-shift row.
// Each input beat runs through a compare step, which checks the item against
// every slot in parallel and registers the flags, and then an update step,
// which shifts the row, updates the class counters and loads the result
// register. A new beat is taken in the cycle the previous one finishes; a
// result that is not taken holds the queue in its update step. Depends on
// spq_pkg, spq_ctrl and spq_datapath.
module sorted_priority_queue_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  spq_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output spq_pkg::out_item_t out_item_o
);

  spq_pkg::dp_cmd_t cmd;

  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  spq_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_item_i  (in_item_i),
    .out_item_o (out_item_o)
  );

endmodule

>>> hdl/spq_checker.sv
// port-level checks of the sorted priority queue, bound to the top level
// depends on spq_pkg and sorted_priority_queue_top_assert.svh
`include "sorted_priority_queue_top_assert.svh"

module spq_assert_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input spq_pkg::out_item_t out_item_o
);

  // a result beat holds until taken
  `SPQ_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_item_o))
  // an empty queue shows a zero head and zero counts
  `SPQ_ASSERT_IMPLY(a_empty_zero, out_valid_o && !out_item_o.head_valid, (out_item_o.head_id == '0) && (out_item_o.head_class == '0) && (out_item_o.count_class0 == '0) && (out_item_o.count_class1 == '0) && (out_item_o.count_other == '0))
  // a dropped insert means the queue holds entries
  `SPQ_ASSERT_IMPLY(a_full_head, out_valid_o && (out_item_o.status == spq_pkg::STATUS_FULL), out_item_o.head_valid)
  // a miss reports no class
  `SPQ_ASSERT_IMPLY(a_miss_cls, out_valid_o && (out_item_o.status == spq_pkg::STATUS_NOT_FOUND), out_item_o.found_class == '0)
  // the compare cycle after an accepted beat takes no input
  `SPQ_ASSERT_NEXT(a_in_gap, in_valid_i && in_ready_o, !in_ready_o)

endmodule

bind sorted_priority_queue_top spq_assert_checker u_spq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);
